// ===== src/sgd_matrix_factorization_update_defines.svh =====
// assertion macros used by the checker file of the sgd update block
// no dependencies; expects clk and rst_n in the including scope
`ifndef SGD_MATRIX_FACTORIZATION_UPDATE_DEFINES_SVH
`define SGD_MATRIX_FACTORIZATION_UPDATE_DEFINES_SVH

// checked only while out of reset
`define SGDMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SGDMF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sgdmf_pkg.sv =====
// shared types, op codes and fixed-point helpers for the sgd update block
// no dependencies
package sgdmf_pkg;

    localparam int LATENT_DEF = 20;
    localparam int USERS_DEF  = 4096;
    localparam int MOVIES_DEF = 4096;

    localparam logic [15:0] STEP_RESET   = 16'd66;
    localparam logic [15:0] LAMBDA_RESET = 16'd66;

    localparam logic [2:0] OP_TRAIN    = 3'd0;
    localparam logic [2:0] OP_PREDICT  = 3'd1;
    localparam logic [2:0] OP_WR_USER  = 3'd2;
    localparam logic [2:0] OP_WR_MOVIE = 3'd3;
    localparam logic [2:0] OP_RD_USER  = 3'd4;
    localparam logic [2:0] OP_RD_MOVIE = 3'd5;

    localparam logic [1:0] REG_STEP   = 2'd0;
    localparam logic [1:0] REG_LAMBDA = 2'd1;

    localparam logic signed [63:0] Q_MAX_W = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN_W = -64'sd2147483648;

    typedef struct packed {
        logic [2:0]         op;
        logic [11:0]        user_index;
        logic [11:0]        movie_index;
        logic [3:0]         rating;
        logic [4:0]         element_index;
        logic signed [31:0] write_value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] prediction;
        logic signed [31:0] error;
        logic signed [31:0] read_value;
        logic               saturated;
    } result_t;

    function automatic logic signed [31:0] sat_q(input logic signed [63:0] x);
        if (x > Q_MAX_W)
            return 32'sh7FFF_FFFF;
        else if (x < Q_MIN_W)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

    function automatic logic ovf_q(input logic signed [63:0] x);
        return (x > Q_MAX_W) || (x < Q_MIN_W);
    endfunction

endpackage

// ===== src/sgdmf_ram.sv =====
// single-port factor memory, one 32-bit element per entry, registered read
// no dependencies
module sgdmf_ram #(
    parameter int DEPTH = 81920,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== src/sgd_matrix_factorization_update.sv =====
// train walks the rows once for the dot product and once for the update; predict only for the dot product
// one item at a time; busy stays high until the result strobe, which ends the item
// the single-port factor memories give one element of each row per access
// done pulses one cycle with the result; results cannot be stalled
// reset clears control and config registers; factor memories hold garbage until written
// depends on sgdmf_pkg and sgdmf_ram
module sgd_matrix_factorization_update #(
    parameter int LATENT = sgdmf_pkg::LATENT_DEF,
    parameter int USERS  = sgdmf_pkg::USERS_DEF,
    parameter int MOVIES = sgdmf_pkg::MOVIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sgdmf_pkg::cmd_t   cmd,
    output logic              done,
    output sgdmf_pkg::result_t result,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    localparam int UAW   = $clog2(USERS * LATENT);
    localparam int MAW   = $clog2(MOVIES * LATENT);
    localparam int JW    = $clog2(LATENT + 1);
    localparam int ACC_W = 49 + $clog2(LATENT) + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DOT_RD  = 4'd1;
    localparam logic [3:0] S_DOT_MUL = 4'd2;
    localparam logic [3:0] S_DOT_ACC = 4'd3;
    localparam logic [3:0] S_ERR     = 4'd4;
    localparam logic [3:0] S_UPD_RD  = 4'd5;
    localparam logic [3:0] S_UPD_MUL = 4'd6;
    localparam logic [3:0] S_UPD_T   = 4'd7;
    localparam logic [3:0] S_UPD_G   = 4'd8;
    localparam logic [3:0] S_UPD_WB  = 4'd9;
    localparam logic [3:0] S_WR      = 4'd10;
    localparam logic [3:0] S_RD      = 4'd11;
    localparam logic [3:0] S_RD_WAIT = 4'd12;

    logic [3:0]  state_reg;
    logic [15:0] step_reg;
    logic [15:0] lambda_reg;
    logic        done_reg;
    sgdmf_pkg::result_t result_reg;

    sgdmf_pkg::cmd_t cmd_reg;
    logic            ok_reg;
    logic [UAW-1:0]  ubase_reg;
    logic [MAW-1:0]  mbase_reg;
    logic [JW-1:0]   j_reg;
    logic            flag_reg;

    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0]      pred_reg;
    logic signed [31:0]      err_reg;
    logic signed [31:0]      u_old_reg;
    logic signed [31:0]      v_old_reg;
    logic signed [63:0]      pu1_reg;
    logic signed [48:0]      pu2_reg;
    logic signed [63:0]      pv1_reg;
    logic signed [48:0]      pv2_reg;
    logic signed [48:0]      tu_reg;
    logic signed [48:0]      tv_reg;
    logic signed [65:0]      gu_reg;
    logic signed [65:0]      gv_reg;

    logic [31:0]        u_rdata;
    logic [31:0]        v_rdata;
    logic signed [31:0] u_q;
    logic signed [31:0] v_q;
    logic               u_we;
    logic               v_we;
    logic [UAW-1:0]     u_addr;
    logic [MAW-1:0]     v_addr;
    logic [31:0]        u_wdata;
    logic [31:0]        v_wdata;
    logic [JW-1:0]      offset;

    logic               accept;
    logic               cmd_ok;
    logic signed [63:0] prod_rnd;
    logic signed [63:0] acc_wide;
    logic signed [63:0] rating_q;
    logic signed [31:0] pred_sat;
    logic signed [63:0] err_wide;
    logic signed [31:0] err_sat;
    logic               err_flags;
    logic signed [64:0] su;
    logic signed [64:0] sv;
    logic signed [66:0] ru;
    logic signed [66:0] rv;
    logic signed [50:0] nu;
    logic signed [50:0] nv;
    logic signed [31:0] nu_sat;
    logic signed [31:0] nv_sat;
    logic               wb_flags;
    logic               last_j;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign u_q    = u_rdata;
    assign v_q    = v_rdata;
    assign last_j = (j_reg == JW'(LATENT - 1));

    always_comb
    begin
        case (cmd.op)
            sgdmf_pkg::OP_TRAIN, sgdmf_pkg::OP_PREDICT:
                cmd_ok = (32'(cmd.user_index) < USERS) && (32'(cmd.movie_index) < MOVIES);
            sgdmf_pkg::OP_WR_USER, sgdmf_pkg::OP_RD_USER:
                cmd_ok = (32'(cmd.user_index) < USERS) && (32'(cmd.element_index) < LATENT);
            sgdmf_pkg::OP_WR_MOVIE, sgdmf_pkg::OP_RD_MOVIE:
                cmd_ok = (32'(cmd.movie_index) < MOVIES) && (32'(cmd.element_index) < LATENT);
            default:
                cmd_ok = 1'b0;
        endcase
    end

    // element offset: fixed element for single-element ops, walking index otherwise
    assign offset  = (state_reg == S_WR || state_reg == S_RD) ? JW'(cmd_reg.element_index)
                                                              : j_reg;
    assign u_addr  = ubase_reg + UAW'(offset);
    assign v_addr  = mbase_reg + MAW'(offset);
    assign u_we    = ((state_reg == S_WR) && ok_reg && (cmd_reg.op == sgdmf_pkg::OP_WR_USER))
                  || (state_reg == S_UPD_WB);
    assign v_we    = ((state_reg == S_WR) && ok_reg && (cmd_reg.op == sgdmf_pkg::OP_WR_MOVIE))
                  || (state_reg == S_UPD_WB);
    assign u_wdata = (state_reg == S_UPD_WB) ? nu_sat : cmd_reg.write_value;
    assign v_wdata = (state_reg == S_UPD_WB) ? nv_sat : cmd_reg.write_value;

    sgdmf_ram #(.DEPTH(USERS * LATENT), .AW(UAW)) u_user_ram (
        .clk   (clk),
        .we    (u_we),
        .addr  (u_addr),
        .wdata (u_wdata),
        .rdata (u_rdata)
    );

    sgdmf_ram #(.DEPTH(MOVIES * LATENT), .AW(MAW)) u_movie_ram (
        .clk   (clk),
        .we    (v_we),
        .addr  (v_addr),
        .wdata (v_wdata),
        .rdata (v_rdata)
    );

    // dot product rounding and error
    assign prod_rnd  = (prod_reg + 64'sd32768) >>> 16;
    assign acc_wide  = 64'(acc_reg);
    assign pred_sat  = sgdmf_pkg::sat_q(acc_wide);
    assign rating_q  = $signed({44'd0, cmd_reg.rating, 16'd0});
    assign err_wide  = 64'(pred_sat) - rating_q;
    assign err_sat   = sgdmf_pkg::sat_q(err_wide);
    assign err_flags = sgdmf_pkg::ovf_q(acc_wide) || sgdmf_pkg::ovf_q(err_wide);

    // t = round(err*other + lambda*self)
    assign su = 65'(pu1_reg) + 65'(pu2_reg) + 65'sd32768;
    assign sv = 65'(pv1_reg) + 65'(pv2_reg) + 65'sd32768;

    // d = round(gamma*t), new = self - d
    assign ru       = 67'(gu_reg) + 67'sd32768;
    assign rv       = 67'(gv_reg) + 67'sd32768;
    assign nu       = 51'(u_old_reg) - 51'(ru[66:16]);
    assign nv       = 51'(v_old_reg) - 51'(rv[66:16]);
    assign nu_sat   = sgdmf_pkg::sat_q(64'(nu));
    assign nv_sat   = sgdmf_pkg::sat_q(64'(nv));
    assign wb_flags = sgdmf_pkg::ovf_q(64'(nu)) || sgdmf_pkg::ovf_q(64'(nv));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= sgdmf_pkg::STEP_RESET;
            lambda_reg <= sgdmf_pkg::LAMBDA_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sgdmf_pkg::REG_STEP:   step_reg   <= cfg_data;
                sgdmf_pkg::REG_LAMBDA: lambda_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            j_reg     <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        j_reg    <= '0;
                        flag_reg <= 1'b0;
                        if (cmd_ok && (cmd.op inside {sgdmf_pkg::OP_TRAIN,
                                                      sgdmf_pkg::OP_PREDICT}))
                            state_reg <= S_DOT_RD;
                        else if (cmd_ok && (cmd.op inside {sgdmf_pkg::OP_RD_USER,
                                                           sgdmf_pkg::OP_RD_MOVIE}))
                            state_reg <= S_RD;
                        else
                            state_reg <= S_WR;
                    end
                end
                S_DOT_RD:  state_reg <= S_DOT_MUL;
                S_DOT_MUL: state_reg <= S_DOT_ACC;
                S_DOT_ACC:
                begin
                    if (last_j)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_DOT_RD;
                    end
                end
                S_ERR:
                begin
                    flag_reg <= err_flags;
                    if (cmd_reg.op == sgdmf_pkg::OP_PREDICT)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_UPD_RD;
                end
                S_UPD_RD:  state_reg <= S_UPD_MUL;
                S_UPD_MUL: state_reg <= S_UPD_T;
                S_UPD_T:   state_reg <= S_UPD_G;
                S_UPD_G:   state_reg <= S_UPD_WB;
                S_UPD_WB:
                begin
                    flag_reg <= flag_reg || wb_flags;
                    if (last_j)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_UPD_RD;
                    end
                end
                S_WR:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_RD:      state_reg <= S_RD_WAIT;
                S_RD_WAIT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg   <= cmd;
                    ok_reg    <= cmd_ok;
                    ubase_reg <= UAW'(32'(cmd.user_index) * LATENT);
                    mbase_reg <= MAW'(32'(cmd.movie_index) * LATENT);
                    acc_reg   <= '0;
                end
            end
            S_DOT_MUL: prod_reg <= u_q * v_q;
            S_DOT_ACC: acc_reg  <= acc_reg + ACC_W'(prod_rnd);
            S_ERR:
            begin
                pred_reg <= pred_sat;
                err_reg  <= err_sat;
                result_reg.prediction <= pred_sat;
                result_reg.error      <= err_sat;
                result_reg.read_value <= '0;
                result_reg.saturated  <= err_flags;
            end
            S_UPD_MUL:
            begin
                u_old_reg <= u_q;
                v_old_reg <= v_q;
                pu1_reg   <= err_reg * v_q;
                pu2_reg   <= $signed({1'b0, lambda_reg}) * u_q;
                pv1_reg   <= err_reg * u_q;
                pv2_reg   <= $signed({1'b0, lambda_reg}) * v_q;
            end
            S_UPD_T:
            begin
                tu_reg <= su[64:16];
                tv_reg <= sv[64:16];
            end
            S_UPD_G:
            begin
                gu_reg <= $signed({1'b0, step_reg}) * tu_reg;
                gv_reg <= $signed({1'b0, step_reg}) * tv_reg;
            end
            S_UPD_WB:
            begin
                result_reg.prediction <= pred_reg;
                result_reg.error      <= err_reg;
                result_reg.read_value <= '0;
                result_reg.saturated  <= flag_reg || wb_flags;
            end
            S_WR:
            begin
                result_reg <= '0;
            end
            S_RD_WAIT:
            begin
                result_reg.prediction <= '0;
                result_reg.error      <= '0;
                result_reg.saturated  <= 1'b0;
                result_reg.read_value <= (cmd_reg.op == sgdmf_pkg::OP_RD_USER) ? u_q : v_q;
            end
            default: ;
        endcase
    end

endmodule

// ===== src/sgdmf_checker.sv =====
// port-level checks for the sgd update block, bound to the top level
// depends on sgdmf_pkg and sgd_matrix_factorization_update_defines.svh
`include "sgd_matrix_factorization_update_defines.svh"

module sgdmf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input sgdmf_pkg::cmd_t    cmd,
    input logic               done,
    input sgdmf_pkg::result_t result,
    input logic               cfg_write,
    input logic [1:0]         cfg_index,
    input logic [15:0]        cfg_data
);

    // busy must be high after every accepted transfer
    `SGDMF_ASSERT(a_busy_after_start, (start && !busy) |=> busy, "busy low after accept")
    `SGDMF_ASSERT(a_done_when_free, done |-> !busy, "result strobe while still busy")
    `SGDMF_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
    `SGDMF_ASSERT(a_read_no_pred, (done && result.read_value != 0) |-> (result.prediction == 0),
                  "read result carries a prediction")
    `SGDMF_ASSERT_RST(a_reset_idle, !rst_n |=> (!busy && !done), "not idle after reset")

endmodule

bind sgd_matrix_factorization_update sgdmf_checker u_sgdmf_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for sgd_matrix_factorization_update: directed and random commands
// depends on sgdmf_pkg and the block; checks every result against an internal predictor
module tb;

    localparam int LAT = sgdmf_pkg::LATENT_DEF;
    localparam int NROW = 8;            // rows used by the stimulus
    localparam longint LIMIT = 3000000;

    // ops outside the defined set and a register index beyond the list
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [1:0] REG_NONE    = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    sgdmf_pkg::cmd_t cmd = '0;
    logic done;
    sgdmf_pkg::result_t result;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    sgd_matrix_factorization_update i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_write(cfg_write),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic signed [31:0] user_rows [int][int];
    logic signed [31:0] movie_rows [int][int];
    bit user_ok [int];     // row fully written
    bit movie_ok [int];
    logic [15:0] gamma_q = sgdmf_pkg::STEP_RESET;
    logic [15:0] lambda_q = sgdmf_pkg::LAMBDA_RESET;

    sgdmf_pkg::cmd_t pending_cmds [$];
    sgdmf_pkg::result_t expected_results [$];
    int send_idle_pct = 0;
    int mismatches = 0;
    longint cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp(input logic signed [63:0] x,
                                                 inout bit flag);
        if (x > sgdmf_pkg::Q_MAX_W || x < sgdmf_pkg::Q_MIN_W) flag = 1'b1;
        return sgdmf_pkg::sat_q(x);
    endfunction

    function automatic sgdmf_pkg::result_t predict_result(input sgdmf_pkg::cmd_t c);
        sgdmf_pkg::result_t r;
        logic signed [31:0] uo [LAT];
        logic signed [31:0] vo [LAT];
        logic signed [63:0] acc, t, d;
        logic signed [31:0] pred, err;
        bit flag;
        int u, m, el;
        r = '0;
        flag = 1'b0;
        u = int'(c.user_index);
        m = int'(c.movie_index);
        el = int'(c.element_index);
        if (c.op inside {sgdmf_pkg::OP_TRAIN, sgdmf_pkg::OP_PREDICT})
        begin
            acc = 0;
            for (int j = 0; j < LAT; j++)
            begin
                uo[j] = user_rows[u][j];
                vo[j] = movie_rows[m][j];
                acc += rnd16(64'(uo[j]) * 64'(vo[j]));
            end
            pred = clamp(acc, flag);
            err = clamp(64'(pred) - 64'(c.rating) * 65536, flag);
            if (c.op == sgdmf_pkg::OP_TRAIN)
            begin
                for (int j = 0; j < LAT; j++)
                begin
                    t = rnd16(64'(err) * 64'(vo[j]) + 64'(lambda_q) * 64'(uo[j]));
                    d = rnd16(64'(gamma_q) * t);
                    user_rows[u][j] = clamp(64'(uo[j]) - d, flag);
                    t = rnd16(64'(err) * 64'(uo[j]) + 64'(lambda_q) * 64'(vo[j]));
                    d = rnd16(64'(gamma_q) * t);
                    movie_rows[m][j] = clamp(64'(vo[j]) - d, flag);
                end
            end
            r.prediction = pred;
            r.error = err;
            r.saturated = flag;
        end
        else if (c.op inside {[sgdmf_pkg::OP_WR_USER:sgdmf_pkg::OP_RD_MOVIE]} && el < LAT)
        begin
            if (c.op == sgdmf_pkg::OP_WR_USER) user_rows[u][el] = c.write_value;
            else if (c.op == sgdmf_pkg::OP_WR_MOVIE) movie_rows[m][el] = c.write_value;
            else if (c.op == sgdmf_pkg::OP_RD_USER) r.read_value = user_rows[u][el];
            else r.read_value = movie_rows[m][el];
        end
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.insert(expected_results.size(), predict_result(cmd));
                start <= 1'b0;
            end
            else if (!start && pending_cmds.size() > 0
                     && $urandom_range(99) >= send_idle_pct)
            begin
                cmd <= pending_cmds.pop_front();
                start <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        sgdmf_pkg::result_t want;
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", result);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.prediction !== want.prediction || result.error !== want.error
                    || result.read_value !== want.read_value
                    || result.saturated !== want.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, result);
                end
            end
        end
        if (cycles >= LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_cmd(input sgdmf_pkg::cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // row choice: only rows whose elements are all written are used, row 0 otherwise
    function automatic int pick_row(input bit is_user);
        int r;
        r = int'($urandom_range(NROW - 1));
        return is_user ? (user_ok.exists(r) ? r : 0) : (movie_ok.exists(r) ? r : 0);
    endfunction

    function automatic logic signed [31:0] small_val();
        return $signed($urandom_range(65536 * 2)) - 32'sd65536;
    endfunction

    function automatic sgdmf_pkg::cmd_t make_cmd(input logic [2:0] op, input int u,
                                                 input int m, input int el,
                                                 input logic signed [31:0] wv);
        sgdmf_pkg::cmd_t c;
        c = '0;
        c.op = op;
        c.user_index = 12'(u);
        c.movie_index = 12'(m);
        c.rating = 4'($urandom_range(15));
        c.element_index = 5'(el);
        c.write_value = wv;
        return c;
    endfunction

    task automatic fill_row(input bit is_user, input int row, input bit wild);
        for (int j = 0; j < LAT; j++)
            queue_cmd(make_cmd(is_user ? sgdmf_pkg::OP_WR_USER : sgdmf_pkg::OP_WR_MOVIE,
                               row, row, j, wild ? $signed($urandom) : small_val()));
        if (is_user) user_ok[row] = 1'b1; else movie_ok[row] = 1'b1;
    endtask

    task automatic drain(input int tail);
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == sgdmf_pkg::REG_STEP) gamma_q = val;
        else if (idx == sgdmf_pkg::REG_LAMBDA) lambda_q = val;
    endtask

    task automatic random_items(input int n);
        int sel, u, m;
        sgdmf_pkg::cmd_t c;
        for (int k = 0; k < n; k++)
        begin
            sel = int'($urandom_range(99));
            u = pick_row(1);
            m = pick_row(0);
            if (sel < 45)
                c = make_cmd(sgdmf_pkg::OP_TRAIN, u, m, 0, $urandom);
            else if (sel < 60)
                c = make_cmd(sgdmf_pkg::OP_PREDICT, u, m, 0, $urandom);
            else if (sel < 70)
                c = make_cmd(sgdmf_pkg::OP_WR_USER, u, m, int'($urandom_range(LAT - 1)),
                             $urandom_range(1) ? small_val() : $signed($urandom));
            else if (sel < 78)
                c = make_cmd(sgdmf_pkg::OP_WR_MOVIE, u, m, int'($urandom_range(LAT - 1)),
                             small_val());
            else if (sel < 86)
                c = make_cmd(sgdmf_pkg::OP_RD_USER, u, m, int'($urandom_range(31)), $urandom);
            else if (sel < 94)
                c = make_cmd(sgdmf_pkg::OP_RD_MOVIE, u, m, int'($urandom_range(31)), $urandom);
            else
            begin
                // unused ops and out-of-range elements on writes
                c = make_cmd($urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI,
                             int'($urandom_range(4095)), int'($urandom_range(4095)),
                             int'($urandom_range(31)), $urandom);
                if ($urandom_range(1))
                begin
                    c.op = $urandom_range(1) ? sgdmf_pkg::OP_WR_USER : sgdmf_pkg::OP_WR_MOVIE;
                    c.element_index = 5'($urandom_range(31, LAT));
                end
            end
            c.rating = 4'($urandom);
            queue_cmd(c);
        end
    endtask

    initial
    begin
        sgdmf_pkg::cmd_t c;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme rows, extreme values, every op
        send_idle_pct = 34;
        fill_row(1, 0, 0);
        fill_row(0, 0, 0);
        fill_row(1, 4095, 1);
        fill_row(0, 4095, 1);
        c = make_cmd(sgdmf_pkg::OP_PREDICT, 4095, 4095, 0, 0);
        c.rating = 4'hF;
        queue_cmd(c);   // saturating dot product
        c = make_cmd(sgdmf_pkg::OP_TRAIN, 4095, 4095, 0, 0);
        c.rating = 4'h0;
        queue_cmd(c);
        c = make_cmd(sgdmf_pkg::OP_TRAIN, 0, 0, 0, 0);
        c.rating = 4'hF;
        queue_cmd(c);
        queue_cmd(make_cmd(sgdmf_pkg::OP_RD_USER, 4095, 0, LAT - 1, 0));
        queue_cmd(make_cmd(sgdmf_pkg::OP_RD_MOVIE, 0, 4095, 0, 0));
        queue_cmd(make_cmd(sgdmf_pkg::OP_RD_USER, 0, 0, 31, 0));       // element out of range
        queue_cmd(make_cmd(sgdmf_pkg::OP_WR_MOVIE, 0, 0, LAT, 32'sh7FFF_FFFF)); // ignored
        queue_cmd(make_cmd(OP_SPARE_LO, 4095, 4095, 31, 32'sh8000_0000));
        queue_cmd(make_cmd(OP_SPARE_HI, 0, 0, 0, 32'sh7FFF_FFFF));
        queue_cmd(make_cmd(sgdmf_pkg::OP_WR_USER, 0, 0, 5, 32'sh8000_0000));
        queue_cmd(make_cmd(sgdmf_pkg::OP_RD_USER, 0, 0, 5, 0));
        queue_cmd(make_cmd(sgdmf_pkg::OP_WR_USER, 0, 0, 5, 32'sh7FFF_FFFF));
        queue_cmd(make_cmd(sgdmf_pkg::OP_TRAIN, 0, 0, 0, 0));
        for (int r = 1; r < NROW; r++)
        begin
            fill_row(1, r, 0);
            fill_row(0, r, 0);
        end
        drain(4);

        // random phases with register changes between them, extremes included
        write_reg(sgdmf_pkg::REG_STEP, 16'hFFFF);
        write_reg(sgdmf_pkg::REG_LAMBDA, 16'h0000);
        random_items(170);
        drain(4);
        send_idle_pct = 70;
        write_reg(sgdmf_pkg::REG_STEP, 16'h0000);
        write_reg(sgdmf_pkg::REG_LAMBDA, 16'hFFFF);
        write_reg(REG_NONE, 16'h1234);   // beyond the register list
        random_items(170);
        drain(4);
        send_idle_pct = 0;
        write_reg(sgdmf_pkg::REG_STEP, 16'($urandom));
        write_reg(sgdmf_pkg::REG_LAMBDA, 16'($urandom));
        random_items(170);
        drain(4);
        write_reg(sgdmf_pkg::REG_STEP, 16'd655);
        write_reg(sgdmf_pkg::REG_LAMBDA, 16'd66);
        random_items(170);
        drain(200);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
